// File: rtl/kmi_pkg.sv
// kmi_pkg: shared constants, codes and control/status types for the
// keyframe matrix interpolator; no dependencies
package kmi_pkg;

    localparam int KMI_MAX_KEYS  = 32;
    localparam int KMI_MAX_BONES = 16;

    // field widths
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 5;
    localparam int BONE_W  = 8;
    localparam int ELEM_W  = 4;
    localparam int FRAME_W = 16;
    localparam int VAL_W   = 32;
    localparam int QF_W    = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BONE_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TOTAL   = 2'd2;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD_FRAME = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_ELEM  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

    localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic mod_step;
        logic wrap;
        logic scan_rd;
        logic scan_cmp;
        logic frac_init;
        logic frac_step;
        logic el_rd;
        logic el_mul;
        logic el_sum;
        logic next_elem;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ident;
        logic mod_last;
        logic scan_stop;
        logic frac_short;
        logic frac_last;
        logic elem_last;
    } t_stat;

endpackage

// File: rtl/kmi_in_if.sv
// kmi_in_if: input item channel of the interpolator
// depends on kmi_pkg
interface kmi_in_if;
    logic                             valid;
    logic                             ready;
    logic [kmi_pkg::OP_W-1:0]         opcode;
    logic [kmi_pkg::SLOT_W-1:0]       key_slot;
    logic [kmi_pkg::BONE_W-1:0]       bone_index;
    logic [kmi_pkg::ELEM_W-1:0]       element_index;
    logic [kmi_pkg::FRAME_W-1:0]      key_frame_value;
    logic signed [kmi_pkg::VAL_W-1:0] element_value;
    logic signed [kmi_pkg::QF_W-1:0]  query_frame;

    modport source (output valid, opcode, key_slot, bone_index, element_index,
                    key_frame_value, element_value, query_frame, input ready);
    modport sink (input valid, opcode, key_slot, bone_index, element_index,
                  key_frame_value, element_value, query_frame, output ready);
endinterface

// File: rtl/kmi_out_if.sv
// kmi_out_if: result item channel of the interpolator
// depends on kmi_pkg
interface kmi_out_if;
    logic                             valid;
    logic                             ready;
    logic [kmi_pkg::ELEM_W-1:0]       out_element;
    logic signed [kmi_pkg::VAL_W-1:0] out_value;
    logic                             out_last;

    modport source (output valid, out_element, out_value, out_last, input ready);
    modport sink (input valid, out_element, out_value, out_last, output ready);
endinterface

// File: rtl/kmi_ctrl.sv
// kmi_ctrl: sequencing state machine of the interpolator
// depends on kmi_pkg (opcodes, command and status types)
module kmi_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [kmi_pkg::OP_W-1:0]  i_opcode,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  kmi_pkg::t_stat            i_stat,
    output kmi_pkg::t_cmd             o_cmd
);
    import kmi_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MOD       = 4'd1;
    localparam logic [3:0] S_WRAP      = 4'd2;
    localparam logic [3:0] S_SCAN_RD   = 4'd3;
    localparam logic [3:0] S_SCAN_CMP  = 4'd4;
    localparam logic [3:0] S_FRAC_INIT = 4'd5;
    localparam logic [3:0] S_FRAC      = 4'd6;
    localparam logic [3:0] S_EL_RD     = 4'd7;
    localparam logic [3:0] S_EL_MUL    = 4'd8;
    localparam logic [3:0] S_EL_SUM    = 4'd9;
    localparam logic [3:0] S_EL_OUT    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode == OP_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) n_state = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = i_stat.ident ? S_EL_RD : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_stat.scan_stop ? S_FRAC_INIT : S_SCAN_RD;
            end
            S_FRAC_INIT: begin
                o_cmd.frac_init = 1'b1;
                n_state         = i_stat.frac_short ? S_EL_RD : S_FRAC;
            end
            S_FRAC: begin
                o_cmd.frac_step = 1'b1;
                if (i_stat.frac_last) n_state = S_EL_RD;
            end
            S_EL_RD: begin
                o_cmd.el_rd = 1'b1;
                n_state     = S_EL_MUL;
            end
            S_EL_MUL: begin
                o_cmd.el_mul = 1'b1;
                n_state      = S_EL_SUM;
            end
            S_EL_SUM: begin
                o_cmd.el_sum = 1'b1;
                n_state      = S_EL_OUT;
            end
            S_EL_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.next_elem = 1'b1;
                    n_state = i_stat.elem_last ? S_IDLE : S_EL_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// File: rtl/kmi_datapath.sv
// kmi_datapath: key stores, configuration, modulo/fraction divider, key scan
// and element blend; depends on kmi_pkg
module kmi_datapath #(
    parameter int MAX_KEYS  = kmi_pkg::KMI_MAX_KEYS,
    parameter int MAX_BONES = kmi_pkg::KMI_MAX_BONES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kmi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [kmi_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [kmi_pkg::OP_W-1:0]            i_opcode,
    input  logic [kmi_pkg::SLOT_W-1:0]          i_key_slot,
    input  logic [kmi_pkg::BONE_W-1:0]          i_bone_index,
    input  logic [kmi_pkg::ELEM_W-1:0]          i_element_index,
    input  logic [kmi_pkg::FRAME_W-1:0]         i_key_frame_value,
    input  logic signed [kmi_pkg::VAL_W-1:0]    i_element_value,
    input  logic signed [kmi_pkg::QF_W-1:0]     i_query_frame,
    input  kmi_pkg::t_cmd                       i_cmd,
    output kmi_pkg::t_stat                      o_stat,
    output logic [kmi_pkg::ELEM_W-1:0]          o_out_element,
    output logic signed [kmi_pkg::VAL_W-1:0]    o_out_value,
    output logic                                o_out_last
);
    import kmi_pkg::*;

    localparam int KW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int BW   = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int AW   = KW + BW + ELEM_W;
    localparam int LW   = QF_W;          // wrap length frame_total*256
    localparam int WW   = QF_W + 1;      // wrapped frame, signed
    localparam int DW   = VAL_W + 1;     // element difference
    localparam int PW   = DW + FRAME_W + 1;
    localparam int MOD_STEPS  = QF_W;
    localparam int FRAC_STEPS = 16;

    // configuration registers
    logic [4:0]         r_bone_total;
    logic [FRAME_W-1:0] r_frame_total;
    logic [5:0]         r_key_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_total  <= '0;
            r_frame_total <= '0;
            r_key_total   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BONE_TOTAL:  r_bone_total  <= i_cfg_data[4:0];
                CFG_FRAME_TOTAL: r_frame_total <= i_cfg_data;
                CFG_KEY_TOTAL:   r_key_total   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // stores
    logic [FRAME_W-1:0] frame_mem [MAX_KEYS];
    logic [VAL_W-1:0]   mat_mem   [2**AW];

    logic [KW-1:0] ld_key;
    logic [AW-1:0] ld_addr;
    logic          slot_ok;
    logic          bone_ok;

    assign ld_key  = KW'(i_key_slot);
    assign ld_addr = {ld_key, i_bone_index[BW-1:0], i_element_index};
    assign slot_ok = 32'(i_key_slot) < MAX_KEYS;
    assign bone_ok = 32'(i_bone_index) < MAX_BONES;

    // query registers
    logic [BONE_W-1:0]     r_bone;
    logic                  r_qneg;
    logic signed [QF_W-1:0] r_qf;
    logic                  r_ident;
    logic [LW-1:0]         r_mag;
    logic [LW:0]           r_rem;
    logic [4:0]            r_cnt;
    logic signed [WW-1:0]  r_w;
    logic [KW-1:0]         r_idx;
    logic [KW-1:0]         r_bi;
    logic [KW-1:0]         r_ai;
    logic [FRAME_W-1:0]    r_fb;
    logic [FRAME_W-1:0]    r_fa;
    logic [FRAME_W-1:0]    r_kf;
    logic [LW-1:0]         r_d;
    logic [15:0]           r_a;
    logic [ELEM_W-1:0]     r_elem;
    logic [VAL_W-1:0]      r_ml;
    logic [VAL_W-1:0]      r_mr;
    logic signed [PW-1:0]  r_prod;
    logic signed [VAL_W-1:0] r_left;

    // modulo step
    logic [LW-1:0] len;
    logic [LW:0]   mod_t;
    logic          mod_ge;
    assign len    = {r_frame_total, 8'd0};
    assign mod_t  = {r_rem[LW-1:0], r_mag[LW-1]};
    assign mod_ge = mod_t >= {1'b0, len};

    // wrapped frame
    logic signed [WW-1:0] w_val;
    always_comb begin
        if (len == '0)                 w_val = WW'(r_qf);
        else if (r_qneg && r_rem != '0) w_val = $signed({1'b0, len} - r_rem);
        else if (r_qneg)                w_val = '0;
        else                            w_val = $signed(r_rem);
    end

    // key compare
    logic signed [WW-1:0] kf_q;
    logic                 kf_le;
    logic                 kf_ge;
    logic [KW-1:0]        last_idx;
    logic                 scan_last;
    assign kf_q     = $signed({1'b0, r_kf, 8'd0});
    assign kf_le    = kf_q <= r_w;
    assign kf_ge    = kf_q >= r_w;
    assign last_idx = (32'(r_key_total) >= MAX_KEYS) ? KW'(MAX_KEYS - 1)
                                                     : KW'(32'(r_key_total) - 1);
    assign scan_last = r_idx == last_idx;

    // fraction setup
    logic signed [WW:0] num;
    logic [FRAME_W-1:0] fdiff;
    logic               no_span;
    logic               num_le0;
    logic               num_big;
    assign num     = $signed({r_w[WW-1], r_w}) - $signed({2'b00, r_fb, 8'd0});
    assign fdiff   = r_fa - r_fb;
    assign no_span = r_fa <= r_fb;
    assign num_le0 = num <= 0;
    assign num_big = num >= $signed({2'b00, fdiff, 8'd0});

    // fraction step
    logic [LW:0] frac_t;
    logic        frac_ge;
    assign frac_t  = {r_rem[LW-1:0], 1'b0};
    assign frac_ge = frac_t >= {1'b0, r_d};

    // blend
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] blend;
    assign diff  = $signed({r_mr[VAL_W-1], r_mr}) - $signed({r_ml[VAL_W-1], r_ml});
    assign prod  = PW'(diff) * $signed({{(PW-17){1'b0}}, 1'b0, r_a});
    assign blend = PW'(r_left) + (r_prod >>> 16);

    assign o_stat.ident      = r_ident;
    assign o_stat.mod_last   = r_cnt == 5'(MOD_STEPS - 1);
    assign o_stat.scan_stop  = kf_ge || scan_last;
    assign o_stat.frac_short = no_span || num_le0 || num_big;
    assign o_stat.frac_last  = r_cnt == 5'(FRAC_STEPS - 1);
    assign o_stat.elem_last  = r_elem == '1;

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_opcode == OP_LOAD_FRAME && slot_ok)
            frame_mem[ld_key] <= i_key_frame_value;
        if (i_cmd.accept && i_opcode == OP_LOAD_ELEM && slot_ok && bone_ok)
            mat_mem[ld_addr] <= i_element_value;
        if (i_cmd.scan_rd) r_kf <= frame_mem[r_idx];
        if (i_cmd.el_rd) begin
            r_ml <= mat_mem[{r_bi, r_bone[BW-1:0], r_elem}];
            r_mr <= mat_mem[{r_ai, r_bone[BW-1:0], r_elem}];
        end
    end

    // query sequencing registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bone  <= i_bone_index;
            r_qf    <= i_query_frame;
            r_qneg  <= i_query_frame[QF_W-1];
            r_mag   <= i_query_frame[QF_W-1] ? LW'(-i_query_frame) : LW'(i_query_frame);
            r_ident <= ({1'b0, i_bone_index} >= {4'd0, r_bone_total})
                       || !bone_ok || r_key_total == '0;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_elem  <= '0;
            r_a     <= '0;
        end
        if (i_cmd.mod_step) begin
            r_rem <= mod_ge ? mod_t - {1'b0, len} : mod_t;
            r_mag <= {r_mag[LW-2:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.wrap) begin
            r_w   <= w_val;
            r_idx <= '0;
            r_bi  <= '0;
            r_ai  <= '0;
        end
        if (i_cmd.scan_cmp) begin
            if (r_idx == '0) r_fb <= r_kf;
            if (kf_le) begin
                r_bi <= r_idx;
                r_fb <= r_kf;
            end
            if (kf_ge || scan_last) begin
                r_ai <= r_idx;
                r_fa <= r_kf;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.frac_init) begin
            r_cnt <= '0;
            r_d   <= {fdiff, 8'd0};
            r_rem <= (LW+1)'(num);
            if (no_span || num_le0) r_a <= '0;
            else if (num_big)       r_a <= 16'hFFFF;
            else                    r_a <= '0;
        end
        if (i_cmd.frac_step) begin
            r_rem <= frac_ge ? frac_t - {1'b0, r_d} : frac_t;
            r_a   <= {r_a[14:0], frac_ge};
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.el_mul) begin
            r_prod <= prod;
            r_left <= $signed(r_ml);
        end
        if (i_cmd.el_sum) begin
            o_out_element <= r_elem;
            o_out_last    <= r_elem == '1;
            if (r_ident)
                o_out_value <= (r_elem == 4'd0 || r_elem == 4'd5 || r_elem == 4'd10
                                || r_elem == 4'd15) ? ONE_Q16 : '0;
            else
                o_out_value <= blend[VAL_W-1:0];
        end
        if (i_cmd.next_elem) r_elem <= r_elem + 1'b1;
    end

endmodule

// File: rtl/keyframe_matrix_interpolator_unit.sv
// keyframe_matrix_interpolator_unit: top level; depends on kmi_pkg, kmi_in_if, kmi_out_if
// load items are accepted in idle; a query runs the accept, 24 modulo steps and one wrap,
// a key scan and the blend fraction divider (both skipped for identity), then read,
// multiply, sum and output for each of 16 elements, output held by result stalls, using the
// bit-serial dividers, the key scan and the single element multiplier; one item in work
// synchronous active-low reset clears the controller and configuration registers
module keyframe_matrix_interpolator_unit #(
    parameter int MAX_KEYS  = kmi_pkg::KMI_MAX_KEYS,
    parameter int MAX_BONES = kmi_pkg::KMI_MAX_BONES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kmi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kmi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    kmi_in_if.sink                           i_item,
    kmi_out_if.source                        o_result
);
    import kmi_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    kmi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_opcode    (i_item.opcode),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // stores and arithmetic
    kmi_datapath #(
        .MAX_KEYS  (MAX_KEYS),
        .MAX_BONES (MAX_BONES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_item.opcode),
        .i_key_slot        (i_item.key_slot),
        .i_bone_index      (i_item.bone_index),
        .i_element_index   (i_item.element_index),
        .i_key_frame_value (i_item.key_frame_value),
        .i_element_value   (i_item.element_value),
        .i_query_frame     (i_item.query_frame),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_element     (o_result.out_element),
        .o_out_value       (o_result.out_value),
        .o_out_last        (o_result.out_last)
    );

endmodule
